// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the pending request tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define PRT_ASSERT_NOW(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define PRT_ASSERT_IMPL(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/prt_pkg.sv =====
// Types and constants of the pending request tracker.
package prt_pkg;

  // Command codes of an input transaction.
  localparam logic [2:0] CMD_BEGIN         = 3'd0;
  localparam logic [2:0] CMD_GET           = 3'd1;
  localparam logic [2:0] CMD_TAKE          = 3'd2;
  localparam logic [2:0] CMD_TAKE_ID       = 3'd3;
  localparam logic [2:0] CMD_CANCEL_SOURCE = 3'd4;
  localparam logic [2:0] CMD_CANCEL_ALL    = 3'd5;
  localparam logic [2:0] CMD_CLEAR         = 3'd6;

  // Id value that never names a request.
  localparam logic [31:0] INVALID_ID = 32'd0;

  // Input transaction payload.
  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] req_id;
    logic [31:0] req_source;
    logic [31:0] req_kind;
    logic [63:0] req_generation;
  } prt_req_t;

  // Result transaction payload.
  typedef struct packed {
    logic        ok;
    logic [31:0] out_id;
    logic [31:0] out_source;
    logic [31:0] out_kind;
    logic [63:0] out_generation;
    logic        last;
  } prt_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec_single;
    logic start_cancel;
    logic cancel_step;
  } prt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic req_is_cancel;
    logic pend_empty;
    logic pend_last;
  } prt_status_t;

endpackage

// ===== rtl/pending_request_tracker_core.sv =====
// Top level of the pending request tracker: controller, datapath and checks.
//
// A table of TABLE_SLOTS outstanding requests keyed by id. The input channel
// (in_valid_i, in_ready_o, in_data_i) carries one command per transaction;
// the output channel (out_valid_o, out_ready_i, out_data_o) returns results.
// Begin, get, take, take by id, clear and unused codes give one result each.
// A cancel gives one result per removed entry in slot order, marked last on
// the final one, or a single result with ok clear if nothing matched.
// Steps: a single-result command is accepted, then one parallel match over
// all slots makes its result; a cancel is accepted, one match marks its
// entries, and the removal walk emits one entry per cycle while the single
// result register is free; each result shows in the cycle after its step.
// A new command is accepted while the previous result waits in the output
// register; when the receiver stalls, the block holds its next result until
// the register frees up. Reset empties the table at once; no clearing pass.
module pending_request_tracker_core
  import prt_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  prt_req_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output prt_rsp_t out_data_o
);

  prt_cmd_t    cmd;
  prt_status_t status;

  // Sequencing of each transaction.
  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Slot table and result register.
  prt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Design checks.
`include "assert_macros.svh"

  `PRT_ASSERT_NOW(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
  `PRT_ASSERT_IMPL(a_single_free, cmd.exec_single, status.out_free, "result overwritten")
  `PRT_ASSERT_IMPL(a_step_free, cmd.cancel_step, status.out_free, "cancel result overwritten")
  `PRT_ASSERT_IMPL(a_idle_quiet, in_ready_o, !cmd.exec_single && !cmd.cancel_step,
                   "result produced while idle")

endmodule

// ===== rtl/prt_ctrl.sv =====
// Controller state machine of the pending request tracker.
module prt_ctrl
  import prt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  prt_status_t status_i,
  output prt_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CANCEL = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.req_is_cancel) begin
          cmd_o.start_cancel = 1'b1;
          state_d            = S_CANCEL;
        end else if (status_i.out_free) begin
          cmd_o.exec_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_CANCEL: begin
        if (status_i.out_free) begin
          cmd_o.cancel_step = 1'b1;
          if (status_i.pend_empty || status_i.pend_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/prt_datapath.sv =====
// Slot table, parallel matching and result register of the pending request tracker.
module prt_datapath
  import prt_pkg::*;
#(
  parameter int TABLE_SLOTS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  prt_req_t    in_data_i,
  input  prt_cmd_t    cmd_i,
  output prt_status_t status_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output prt_rsp_t    out_data_o
);

  localparam logic [TABLE_SLOTS-1:0] ONE = {{(TABLE_SLOTS-1){1'b0}}, 1'b1};

  prt_req_t req_q;

  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  logic [TABLE_SLOTS-1:0] pend_q, pend_d;
  logic [31:0]            slot_id_q  [TABLE_SLOTS];
  logic [31:0]            slot_src_q [TABLE_SLOTS];
  logic [31:0]            slot_kind_q[TABLE_SLOTS];
  logic [63:0]            slot_gen_q [TABLE_SLOTS];

  logic                   out_valid_q, out_valid_d;
  prt_rsp_t               out_q, out_d;

  logic [TABLE_SLOTS-1:0] hit, full, cmatch, low, free_oh, sel_mask, wr_en;
  prt_rsp_t               sel_rsp;
  logic                   out_free, begin_bad;

  // Compare every slot against the held request at once.
  always_comb begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      hit[i]    = valid_q[i] && (slot_id_q[i] == req_q.req_id);
      full[i]   = hit[i] && (slot_src_q[i] == req_q.req_source) &&
                  (slot_kind_q[i] == req_q.req_kind) &&
                  (slot_gen_q[i] == req_q.req_generation);
      cmatch[i] = valid_q[i] &&
                  ((req_q.command == CMD_CANCEL_ALL) || (slot_src_q[i] == req_q.req_source)) &&
                  ((req_q.req_kind == 32'd0) || (slot_kind_q[i] == req_q.req_kind));
    end
  end

  // Lowest pending slot of a cancel and lowest free slot for a begin.
  assign low     = pend_q & (~pend_q + ONE);
  assign free_oh = ~valid_q & (valid_q + ONE);

  // One-hot read of the selected slot; an empty mask reads as zero.
  always_comb begin
    if (cmd_i.cancel_step) begin
      sel_mask = low;
    end else if (req_q.command == CMD_TAKE) begin
      sel_mask = full;
    end else begin
      sel_mask = hit;
    end
    sel_rsp = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (sel_mask[i]) begin
        sel_rsp.out_id         = sel_rsp.out_id | slot_id_q[i];
        sel_rsp.out_source     = sel_rsp.out_source | slot_src_q[i];
        sel_rsp.out_kind       = sel_rsp.out_kind | slot_kind_q[i];
        sel_rsp.out_generation = sel_rsp.out_generation | slot_gen_q[i];
      end
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign begin_bad = (req_q.req_id == INVALID_ID) || (req_q.req_generation == 64'd0) ||
                     (req_q.req_kind == 32'd0) || (|hit) || (&valid_q);

  // Table update and result generation.
  always_comb begin
    valid_d     = valid_q;
    pend_d      = pend_q;
    wr_en       = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.exec_single) begin
      out_valid_d = 1'b1;
      out_d       = '0;
      out_d.last  = 1'b1;
      case (req_q.command)
        CMD_BEGIN: begin
          out_d.ok = !begin_bad;
          if (!begin_bad) begin
            wr_en   = free_oh;
            valid_d = valid_q | free_oh;
          end
        end
        CMD_GET: begin
          out_d      = sel_rsp;
          out_d.ok   = |hit;
          out_d.last = 1'b1;
        end
        CMD_TAKE: begin
          out_d      = sel_rsp;
          out_d.ok   = |full;
          out_d.last = 1'b1;
          valid_d    = valid_q & ~full;
        end
        CMD_TAKE_ID: begin
          out_d      = sel_rsp;
          out_d.ok   = |hit;
          out_d.last = 1'b1;
          valid_d    = valid_q & ~hit;
        end
        CMD_CLEAR: begin
          out_d.ok = 1'b1;
          valid_d  = '0;
        end
        default: begin
          out_d.ok = 1'b0;
        end
      endcase
    end else if (cmd_i.start_cancel) begin
      pend_d = cmatch;
    end else if (cmd_i.cancel_step) begin
      out_valid_d = 1'b1;
      if (pend_q == '0) begin
        out_d      = '0;
        out_d.last = 1'b1;
      end else begin
        out_d      = sel_rsp;
        out_d.ok   = 1'b1;
        out_d.last = status_o.pend_last;
        valid_d    = valid_q & ~low;
        pend_d     = pend_q & ~low;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.out_free      = out_free;
    status_o.req_is_cancel = (req_q.command == CMD_CANCEL_SOURCE) ||
                             (req_q.command == CMD_CANCEL_ALL);
    status_o.pend_empty    = (pend_q == '0);
    status_o.pend_last     = (pend_q != '0) && ((pend_q & ~low) == '0);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: held request and pending result.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    out_q <= out_d;
  end

  // Slot contents, written by a successful begin.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (wr_en[i]) begin
        slot_id_q[i]   <= req_q.req_id;
        slot_src_q[i]  <= req_q.req_source;
        slot_kind_q[i] <= req_q.req_kind;
        slot_gen_q[i]  <= req_q.req_generation;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
